### hdl/lbh_pkg.sv
// Shared types, register map and color helpers for the LED blink HSV controller.
`timescale 1ns / 1ps

package lbh_pkg;

   // Action codes carried by an item
   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_SET      = 3'd1;
   localparam logic [2:0] ACT_TOGGLE   = 3'd2;
   localparam logic [2:0] ACT_BLINK    = 3'd3;
   localparam logic [2:0] ACT_SET_KEEP = 3'd4;

   // Register map, index = byte address / 4
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
   localparam logic [1:0] REG_HUE        = 2'd1;
   localparam logic [1:0] REG_SATURATION = 2'd2;

   localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;

   // Deadline arithmetic runs at this width; a carry out means never reached
   localparam int MATH_BITS = 64;
   // Milliseconds to microseconds
   localparam int MS_TO_US      = 1000;
   localparam int MS_TO_US_BITS = 10;

   // Hue sectors of the color wheel, 43 hue steps each but the last, which has 41
   localparam logic [2:0] SECTOR_RED     = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN   = 3'd2;
   localparam logic [2:0] SECTOR_CYAN    = 3'd3;
   localparam logic [2:0] SECTOR_BLUE    = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA = 3'd5;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] hue;
      logic [7:0] saturation;
   } lbh_cfg_type;

   typedef struct packed {
      logic load;      // take the item and apply its action
      logic dur;       // form the current phase time
      logic cmp;       // check the deadline, flip on expiry
      logic hsv;       // first color stage
      logic out_load;  // second color stage into the result register
   } lbh_cmd_type;

   function automatic logic [2:0] hue_sector(input logic [7:0] h);
      logic [2:0] s;
      if (h < 8'd43)       s = SECTOR_RED;
      else if (h < 8'd86)  s = SECTOR_YELLOW;
      else if (h < 8'd129) s = SECTOR_GREEN;
      else if (h < 8'd172) s = SECTOR_CYAN;
      else if (h < 8'd215) s = SECTOR_BLUE;
      else                 s = SECTOR_MAGENTA;
      return s;
   endfunction

   function automatic logic [7:0] sector_base(input logic [2:0] s);
      logic [7:0] b;
      case (s)
         SECTOR_RED:     b = 8'd0;
         SECTOR_YELLOW:  b = 8'd43;
         SECTOR_GREEN:   b = 8'd86;
         SECTOR_CYAN:    b = 8'd129;
         SECTOR_BLUE:    b = 8'd172;
         default:        b = 8'd215;
      endcase
      return b;
   endfunction

endpackage

### hdl/led_blink_hsv_controller.sv
// Top level of the LED blink HSV controller.
// Drives one LED: each item on the req_ channel carries an action (tick, set, toggle,
// blink start, set keeping blink) and a microsecond timestamp, and answers with one
// item on the rsp_ channel holding the LED state, the PWM duty (brightness when on,
// else zero), the RGB color from integer HSV conversion of hue, saturation and duty,
// and a flag that tells whether this item changed the LED state. Set and toggle stop
// blinking; blink start loads the on and off times in milliseconds, restamps the last
// change and applies the tick rule at once. A tick flips the LED once the current
// phase (on time when lit, off time when dark, times 1000) has passed since the last
// change. An item goes from acceptance to its result by these steps: apply the action,
// form the phase time (one multiply), do the 64-bit deadline add and compare, then the
// color stages with the dependent multiplies of the HSV conversion. The next item is
// taken the cycle after the result is registered, not before. The result register lets a
// new item in while the previous result still waits on rsp_stall. Brightness, hue and
// saturation sit at byte addresses 0, 4 and 8 of the csr_ port; they are to be written
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module led_blink_hsv_controller #(
   parameter int TIME_BITS     = 48,
   parameter int BLINK_MS_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_action,
   input  logic [TIME_BITS-1:0]              req_now_us,
   input  logic                              req_set_value,
   input  logic [BLINK_MS_BITS-1:0]          req_on_ms,
   input  logic [BLINK_MS_BITS-1:0]          req_off_ms,
   // Result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_led_on,
   output logic [7:0]                        rsp_duty,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic                              rsp_state_changed,
   // Configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lbh_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lbh_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lbh_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import lbh_pkg::*;

   lbh_cfg_type cfg;   // brightness, hue, saturation as registered
   lbh_cmd_type cmd;   // one step of the item sequence per cycle unless the result waits

   // Register file; writes land at the access phase of the APB transfer
   lbh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer: accept one item, walk it through the datapath, hold the result
   lbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // LED state, blink deadline check and HSV color pipeline
   lbh_datapath #(
      .TIME_BITS     (TIME_BITS),
      .BLINK_MS_BITS (BLINK_MS_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_action        (req_action),
      .req_now_us        (req_now_us),
      .req_set_value     (req_set_value),
      .req_on_ms         (req_on_ms),
      .req_off_ms        (req_off_ms),
      .rsp_led_on        (rsp_led_on),
      .rsp_duty          (rsp_duty),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_state_changed (rsp_state_changed)
   );

endmodule

### hdl/lbh_csr.sv
// Configuration registers of the LED blink HSV controller behind an APB-style port.
`timescale 1ns / 1ps

module lbh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lbh_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lbh_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lbh_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output lbh_pkg::lbh_cfg_type                cfg
);
   import lbh_pkg::*;

   logic [7:0] brightness_ff, brightness_in;
   logic [7:0] hue_ff, hue_in;
   logic [7:0] saturation_ff, saturation_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      brightness_in = brightness_ff;
      hue_in        = hue_ff;
      saturation_in = saturation_ff;
      if (wr_en) begin
         case (reg_index)
            REG_BRIGHTNESS: brightness_in = csr_pwdata[7:0];
            REG_HUE:        hue_in        = csr_pwdata[7:0];
            REG_SATURATION: saturation_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
         hue_ff        <= 8'd0;
         saturation_ff <= 8'd0;
      end else begin
         brightness_ff <= brightness_in;
         hue_ff        <= hue_in;
         saturation_ff <= saturation_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_BRIGHTNESS: csr_prdata = CSR_DATA_BITS'(brightness_ff);
         REG_HUE:        csr_prdata = CSR_DATA_BITS'(hue_ff);
         REG_SATURATION: csr_prdata = CSR_DATA_BITS'(saturation_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.brightness = brightness_ff;
   assign cfg.hue        = hue_ff;
   assign cfg.saturation = saturation_ff;

endmodule

### hdl/lbh_ctrl.sv
// Sequencer of the LED blink HSV controller: handshakes and datapath commands.
`timescale 1ns / 1ps

module lbh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lbh_pkg::lbh_cmd_type cmd
);
   import lbh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUR,
      ST_CMP,
      ST_HSV1,
      ST_HSV2
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register frees up when empty or when taken this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DUR;
         ST_DUR:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_HSV1;
         ST_HSV1: state_in = ST_HSV2;
         ST_HSV2: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load     = (state_ff == ST_IDLE) & req_valid;
   assign cmd.dur      = (state_ff == ST_DUR);
   assign cmd.cmp      = (state_ff == ST_CMP);
   assign cmd.hsv      = (state_ff == ST_HSV1);
   assign cmd.out_load = (state_ff == ST_HSV2) & out_free;

endmodule

### hdl/lbh_datapath.sv
// Datapath of the LED blink HSV controller: LED state, blink timing and color.
`timescale 1ns / 1ps

module lbh_datapath #(
   parameter int TIME_BITS     = 48,
   parameter int BLINK_MS_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lbh_pkg::lbh_cmd_type     cmd,
   input  lbh_pkg::lbh_cfg_type     cfg,
   input  logic [2:0]               req_action,
   input  logic [TIME_BITS-1:0]     req_now_us,
   input  logic                     req_set_value,
   input  logic [BLINK_MS_BITS-1:0] req_on_ms,
   input  logic [BLINK_MS_BITS-1:0] req_off_ms,
   output logic                     rsp_led_on,
   output logic [7:0]               rsp_duty,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue,
   output logic                     rsp_state_changed
);
   import lbh_pkg::*;

   localparam int DUR_BITS = BLINK_MS_BITS + MS_TO_US_BITS;
   localparam int SUM_BITS = MATH_BITS + 1;

   // LED state
   logic                     lit_ff, lit_in;
   logic [BLINK_MS_BITS-1:0] on_ff, on_in;
   logic [BLINK_MS_BITS-1:0] off_ff, off_in;
   logic [TIME_BITS-1:0]     last_ff, last_in;

   // Item in flight
   logic [TIME_BITS-1:0]     now_ff;
   logic                     tick_ff;
   logic                     changed_ff, changed_in;
   logic [DUR_BITS-1:0]      dur_ff;
   logic                     blink_en_ff;

   // Color stage one
   logic [7:0]  v_ff, p_ff, sr_ff, st_ff;
   logic [2:0]  sector_ff;
   logic        gray_ff;

   // Result register
   logic        out_lit_ff, out_changed_ff;
   logic [7:0]  out_duty_ff, out_red_ff, out_green_ff, out_blue_ff;

   logic [BLINK_MS_BITS-1:0] phase_ms;
   logic [SUM_BITS-1:0]      deadline;
   logic                     expired;

   logic [7:0]  v, hue_off, rem;
   logic [2:0]  sector;
   logic [10:0] rem_wide;
   logic [15:0] p_prod, sr_prod, st_prod, q_prod, t_prod;
   logic [7:0]  q, t;
   logic [7:0]  red, green, blue;

   assign phase_ms = lit_ff ? on_ff : off_ff;
   // A carry out of the deadline sum means the deadline is never reached
   assign deadline = {1'b0, MATH_BITS'(last_ff)} + SUM_BITS'(dur_ff);
   assign expired  = blink_en_ff & ~deadline[MATH_BITS]
                   & (MATH_BITS'(now_ff) > deadline[MATH_BITS-1:0]);

   always_comb begin
      lit_in     = lit_ff;
      on_in      = on_ff;
      off_in     = off_ff;
      last_in    = last_ff;
      changed_in = changed_ff;
      if (cmd.load) begin
         changed_in = 1'b0;
         case (req_action)
            ACT_SET: begin
               on_in      = '0;
               off_in     = '0;
               lit_in     = req_set_value;
               changed_in = (lit_ff != req_set_value);
            end
            ACT_TOGGLE: begin
               on_in      = '0;
               off_in     = '0;
               lit_in     = ~lit_ff;
               changed_in = 1'b1;
            end
            ACT_BLINK: begin
               on_in   = req_on_ms;
               off_in  = req_off_ms;
               last_in = req_now_us;
            end
            ACT_SET_KEEP: begin
               lit_in     = req_set_value;
               changed_in = (lit_ff != req_set_value);
            end
            default: ;
         endcase
      end else if (cmd.cmp && expired) begin
         lit_in     = ~lit_ff;
         last_in    = now_ff;
         changed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff  <= 1'b0;
         on_ff   <= '0;
         off_ff  <= '0;
         last_ff <= '0;
      end else begin
         lit_ff  <= lit_in;
         on_ff   <= on_in;
         off_ff  <= off_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      if (cmd.load) begin
         now_ff  <= req_now_us;
         tick_ff <= (req_action == ACT_TICK) | (req_action == ACT_BLINK);
      end
      if (cmd.dur) begin
         dur_ff      <= DUR_BITS'(phase_ms) * DUR_BITS'(MS_TO_US);
         blink_en_ff <= tick_ff & (on_ff != '0) & (off_ff != '0);
      end
   end

   // Color stage one: sector, remainder and the products with s
   assign v        = lit_ff ? cfg.brightness : 8'd0;
   assign sector   = hue_sector(cfg.hue);
   assign hue_off  = cfg.hue - sector_base(sector);
   assign rem_wide = 11'(hue_off) * 11'd6;
   assign rem      = rem_wide[7:0];
   assign p_prod   = 16'(v) * 16'(8'd255 - cfg.saturation);
   assign sr_prod  = 16'(cfg.saturation) * 16'(rem);
   assign st_prod  = 16'(cfg.saturation) * 16'(8'd255 - rem);

   always_ff @(posedge clock) begin
      if (cmd.hsv) begin
         v_ff      <= v;
         p_ff      <= p_prod[15:8];
         sr_ff     <= sr_prod[15:8];
         st_ff     <= st_prod[15:8];
         sector_ff <= sector;
         gray_ff   <= (cfg.saturation == 8'd0);
      end
   end

   // Color stage two
   assign q_prod = 16'(v_ff) * 16'(8'd255 - sr_ff);
   assign t_prod = 16'(v_ff) * 16'(8'd255 - st_ff);
   assign q      = q_prod[15:8];
   assign t      = t_prod[15:8];

   always_comb begin
      case (sector_ff)
         SECTOR_RED:    begin red = v_ff; green = t;    blue = p_ff; end
         SECTOR_YELLOW: begin red = q;    green = v_ff; blue = p_ff; end
         SECTOR_GREEN:  begin red = p_ff; green = v_ff; blue = t;    end
         SECTOR_CYAN:   begin red = p_ff; green = q;    blue = v_ff; end
         SECTOR_BLUE:   begin red = t;    green = p_ff; blue = v_ff; end
         default:       begin red = v_ff; green = p_ff; blue = q;    end
      endcase
      if (gray_ff) begin
         red   = v_ff;
         green = v_ff;
         blue  = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_lit_ff     <= lit_ff;
         out_changed_ff <= changed_ff;
         out_duty_ff    <= v_ff;
         out_red_ff     <= red;
         out_green_ff   <= green;
         out_blue_ff    <= blue;
      end
   end

   assign rsp_led_on        = out_lit_ff;
   assign rsp_duty          = out_duty_ff;
   assign rsp_red           = out_red_ff;
   assign rsp_green         = out_green_ff;
   assign rsp_blue          = out_blue_ff;
   assign rsp_state_changed = out_changed_ff;

endmodule

### hdl/lbh_checker.sv
// Port-level checks of the LED blink HSV controller and their bind.
`timescale 1ns / 1ps

module lbh_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_led_on,
   input logic [7:0] rsp_duty,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   // One item at a time: an accepted item closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_duty_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_led_on || rsp_duty == 8'd0))
      else $error("nonzero duty with LED off");

   a_color_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_led_on |-> (rsp_red == 8'd0 && rsp_green == 8'd0
                                    && rsp_blue == 8'd0))
      else $error("color shown with LED off");

   // The HSV value always appears as one of the components
   a_value_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == rsp_duty || rsp_green == rsp_duty
                     || rsp_blue == rsp_duty))
      else $error("no color component equals the duty");

endmodule

bind led_blink_hsv_controller lbh_checker u_lbh_checker (.*);
